// File: hdl/tcsc_pkg.sv
// ----------------------------------------------------------------------------
// tcsc_pkg: shared types for the two-clique split checker
// Field widths, and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package tcsc_pkg;

  // Fixed field widths
  localparam int unsigned RowW   = 16;  // one adjacency row per input item
  localparam int unsigned CountW = 5;   // vertex_count register
  localparam int unsigned OutW   = 8;   // output tdata, can_split in bit 0

  // Controller to datapath
  typedef struct packed {
    logic load_row;     // store the incoming row, advance the row count
    logic search_init;  // clear colours, start vertex zero, result true
    logic pick_skip;    // move on to the next start vertex
    logic pick_seed;    // colour the start vertex and put it in the queue
    logic deq;          // read the queue head
    logic row_read;     // read the row of the dequeued vertex, rewind v
    logic scan_step;    // handle neighbor v, step v
    logic res_clr;      // colour conflict found: result false
    logic emit;         // load the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic row_done;       // this row completes the graph
    logic start_end;      // every start vertex tried
    logic start_colored;  // current start vertex already coloured
    logic queue_empty;    // queue head has met tail
    logic conflict;       // neighbor v has the same colour as u
    logic v_last;         // v is the last vertex in use
    logic out_busy;       // output register holds an item not taken
  } sts_t;

endpackage

// File: hdl/tcsc_dp.sv
// ----------------------------------------------------------------------------
// tcsc_dp: datapath of the two-clique split checker
// Row memory, visit queue, colour vectors, counters and the output register.
// ----------------------------------------------------------------------------
module tcsc_dp #(
  parameter int unsigned NUM_VERTICES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcsc_pkg::cmd_t                cmd_i,
  output tcsc_pkg::sts_t                sts_o,
  input  logic                          cfg_valid_i,
  input  logic [tcsc_pkg::CountW-1:0]   cfg_data_i,
  input  logic [tcsc_pkg::RowW-1:0]     row_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          out_data_o
);

  localparam int unsigned VW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int unsigned CW = $clog2(NUM_VERTICES + 1);
  localparam int unsigned MW = (CW > tcsc_pkg::CountW) ? CW : tcsc_pkg::CountW;

  logic [tcsc_pkg::CountW-1:0] vc_q;
  logic [CW-1:0]               rows_q;
  logic [CW-1:0]               start_q;
  logic [CW-1:0]               head_q;
  logic [CW-1:0]               tail_q;
  logic [VW-1:0]               v_q;
  logic [NUM_VERTICES-1:0]     assigned_q;
  logic [NUM_VERTICES-1:0]     side_q;
  logic                        res_q;
  logic                        out_valid_q;
  logic                        out_data_q;

  logic [NUM_VERTICES-1:0]     adj_mem [NUM_VERTICES];
  logic [VW-1:0]               queue_mem [NUM_VERTICES];
  logic [NUM_VERTICES-1:0]     adj_rd_q;
  logic [VW-1:0]               u_q;

  logic [MW-1:0]               vc_ext;
  logic [MW-1:0]               n_sel;
  logic [CW-1:0]               n_act;
  logic [NUM_VERTICES-1:0]     row_ext;
  logic [CW:0]                 rows_next;
  logic                        edge_v;
  logic                        u_side;
  logic                        v_asg;
  logic                        enq;
  logic                        q_we;
  logic [VW-1:0]               q_waddr;
  logic [VW-1:0]               q_wdata;

  // Effective vertex count: zero reads as one, saturate at the array size
  always_comb begin
    vc_ext = MW'(vc_q);
    if (vc_ext == '0) begin
      n_sel = MW'(1);
    end else if (vc_ext > MW'(NUM_VERTICES)) begin
      n_sel = MW'(NUM_VERTICES);
    end else begin
      n_sel = vc_ext;
    end
  end
  assign n_act = CW'(n_sel);

  // Row widened or cut to the vertex range, upper bits zero
  assign row_ext   = NUM_VERTICES'({{NUM_VERTICES{1'b0}}, row_i});
  assign rows_next = {1'b0, rows_q} + (CW+1)'(1);

  // Neighbor test on the complement: no self loop, edge where the row bit is 0
  assign edge_v = !adj_rd_q[v_q] && (v_q != u_q);
  assign u_side = side_q[u_q];
  assign v_asg  = assigned_q[v_q];
  assign enq    = edge_v && !v_asg;

  // Status
  assign sts_o.row_done      = (rows_next >= {1'b0, n_act});
  assign sts_o.start_end     = (start_q == n_act);
  assign sts_o.start_colored = assigned_q[start_q[VW-1:0]];
  assign sts_o.queue_empty   = (head_q == tail_q);
  assign sts_o.conflict      = edge_v && v_asg && (side_q[v_q] == u_side);
  assign sts_o.v_last        = (v_q == VW'(n_act - CW'(1)));
  assign sts_o.out_busy      = out_valid_q && !out_ready_i;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= tcsc_pkg::CountW'(16);
    end else if (cfg_valid_i) begin
      vc_q <= cfg_data_i;
    end
  end

  // Row count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= '0;
    end else if (cmd_i.load_row) begin
      rows_q <= sts_o.row_done ? '0 : rows_next[CW-1:0];
    end
  end

  // Search counters, colours and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      v_q        <= '0;
      assigned_q <= '0;
      side_q     <= '0;
      res_q      <= 1'b0;
    end else begin
      if (cmd_i.search_init) begin
        start_q    <= '0;
        assigned_q <= '0;
        side_q     <= '0;
        res_q      <= 1'b1;
      end
      if (cmd_i.pick_skip) begin
        start_q <= start_q + CW'(1);
      end
      if (cmd_i.pick_seed) begin
        assigned_q[start_q[VW-1:0]] <= 1'b1;
        side_q[start_q[VW-1:0]]     <= 1'b1;
        head_q                      <= '0;
        tail_q                      <= CW'(1);
      end
      if (cmd_i.deq) begin
        head_q <= head_q + CW'(1);
      end
      if (cmd_i.row_read) begin
        v_q <= '0;
      end
      if (cmd_i.scan_step) begin
        v_q <= v_q + VW'(1);
        if (enq) begin
          assigned_q[v_q] <= 1'b1;
          side_q[v_q]     <= !u_side;
          tail_q          <= tail_q + CW'(1);
        end
      end
      if (cmd_i.res_clr) begin
        res_q <= 1'b0;
      end
    end
  end

  // Row memory: written while loading, read at the dequeued vertex
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row) begin
      adj_mem[rows_q[VW-1:0]] <= row_ext;
    end
    if (cmd_i.row_read) begin
      adj_rd_q <= adj_mem[u_q];
    end
  end

  // Visit queue: seed at slot zero, else append at tail
  assign q_we    = cmd_i.pick_seed || (cmd_i.scan_step && enq);
  assign q_waddr = cmd_i.pick_seed ? '0 : tail_q[VW-1:0];
  assign q_wdata = cmd_i.pick_seed ? start_q[VW-1:0] : v_q;

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    if (cmd_i.deq) begin
      u_q <= queue_mem[head_q[VW-1:0]];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hdl/tcsc_ctrl.sv
// ----------------------------------------------------------------------------
// tcsc_ctrl: controller of the two-clique split checker
// Sequences row loading, the breadth-first two-colouring and the result.
// ----------------------------------------------------------------------------
module tcsc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tcsc_pkg::sts_t sts_i,
  output tcsc_pkg::cmd_t cmd_o
);

  localparam logic [2:0] StLoad   = 3'd0;
  localparam logic [2:0] StPick   = 3'd1;
  localparam logic [2:0] StDeq    = 3'd2;
  localparam logic [2:0] StQWait  = 3'd3;
  localparam logic [2:0] StScan   = 3'd4;
  localparam logic [2:0] StFinish = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;

  assign in_ready_o = (state_q == StLoad);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StLoad: begin
        if (in_valid_i) begin
          cmd_o.load_row = 1'b1;
          if (sts_i.row_done) begin
            cmd_o.search_init = 1'b1;
            state_d           = StPick;
          end
        end
      end
      StPick: begin
        if (sts_i.start_end) begin
          state_d = StFinish;
        end else if (sts_i.start_colored) begin
          cmd_o.pick_skip = 1'b1;
        end else begin
          cmd_o.pick_seed = 1'b1;
          state_d         = StDeq;
        end
      end
      StDeq: begin
        if (sts_i.queue_empty) begin
          cmd_o.pick_skip = 1'b1;
          state_d         = StPick;
        end else begin
          cmd_o.deq = 1'b1;
          state_d   = StQWait;
        end
      end
      StQWait: begin
        cmd_o.row_read = 1'b1;
        state_d        = StScan;
      end
      StScan: begin
        if (sts_i.conflict) begin
          cmd_o.res_clr = 1'b1;
          state_d       = StFinish;
        end else begin
          cmd_o.scan_step = 1'b1;
          if (sts_i.v_last) begin
            state_d = StDeq;
          end
        end
      end
      StFinish: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/two_clique_split_check.sv
// ----------------------------------------------------------------------------
// two_clique_split_check: does a directed graph split into two cliques
// Loads the adjacency rows, two-colours the complement breadth first and
// reports whether it is bipartite.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                  Accepted when
// s_axis    in   tdata[15:0] = row_bits                   tvalid & tready
// m_axis    out  tdata[7:0]  = can_split in bit 0         tvalid & tready
// cfg       in   cfg_data[4:0] = vertex_count             cfg_valid & cfg_ready
//
// Rows are taken one per cycle while no search runs. The last row of a graph
// starts the search: each dequeued vertex goes through a queue read and a row
// memory read, then a scan of its neighbor bits, one bit per cycle. Input is
// not taken during the search; a result waiting in the output register holds
// the next finished search, and with it the input, until it is taken. Reset
// clears the row count and sets vertex_count to 16.
// ----------------------------------------------------------------------------
module two_clique_split_check #(
  parameter int unsigned NUM_VERTICES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [tcsc_pkg::RowW-1:0]   s_axis_tdata_i,   // [15:0] row_bits
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [tcsc_pkg::OutW-1:0]   m_axis_tdata_o,   // [0] can_split, [7:1] zero
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tcsc_pkg::CountW-1:0] cfg_data_i        // [4:0] vertex_count
);

  tcsc_pkg::cmd_t cmd;
  tcsc_pkg::sts_t sts;
  logic           out_bit;

  // Register writes are always taken
  assign cfg_ready_o = 1'b1;

  tcsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcsc_dp #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .row_i       (s_axis_tdata_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (out_bit)
  );

  assign m_axis_tdata_o = {(tcsc_pkg::OutW-1)'(0), out_bit};

endmodule

// File: hdl/tcsc_checker.sv
// ----------------------------------------------------------------------------
// tcsc_checker: port-level checks for the two-clique split checker
// Watches the stream ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module tcsc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [tcsc_pkg::OutW-1:0]   m_axis_tdata_o
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed or dropped while stalled");

  // Input closes only right after a row was taken
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(s_axis_tready_o) |-> $past(s_axis_tvalid_i))
    else $error("input closed without a completing row");

  // A new result appears only at the end of a search, never while loading
  a_result_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(s_axis_tready_o))
    else $error("result raised while rows were being loaded");

  // Padding bits above can_split stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[tcsc_pkg::OutW-1:1] == '0)
    else $error("nonzero padding in result");

endmodule

bind two_clique_split_check tcsc_checker u_tcsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for two_clique_split_check
// Feeds adjacency rows one item at a time and predicts each split verdict
// with a breadth-first two-colouring of the complement. The vertex count is
// changed between graphs and also in the middle of one. Both stream sides
// idle at random, and one long output hold-off fills the block up.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MAX_V           = 16;
  localparam int unsigned TOTAL_ROWS      = 1250;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned ROW_SETTLE      = 8;    // a row that ends no graph starts no search
  localparam int unsigned DRAIN_CYCLES    = 400;
  localparam int unsigned STALL_LIMIT     = 5000;

  logic                        clk_i     = 1'b0;
  logic                        rst_ni    = 1'b0;
  logic                        s_tvalid  = 1'b0;
  logic [tcsc_pkg::RowW-1:0]   s_tdata   = '0;
  logic                        s_tready;
  logic                        m_tvalid;
  logic                        m_tready  = 1'b0;
  logic [tcsc_pkg::OutW-1:0]   m_tdata;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [tcsc_pkg::CountW-1:0] cfg_data  = '0;

  // Shadow of the block: stored rows, row count and vertex_count
  logic [tcsc_pkg::RowW-1:0]   row_store [MAX_V];
  int unsigned                 rows_held = 0;
  logic [tcsc_pkg::CountW-1:0] count_reg = tcsc_pkg::CountW'(16);
  bit                          split_expected [$];

  int unsigned errors        = 0;
  int unsigned rows_sent     = 0;
  bit          no_idle       = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned rx_wait       = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  bit          want_split;

  two_clique_split_check #(
    .NUM_VERTICES(MAX_V)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),    // [15:0] row_bits
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),    // [0] can_split, [7:1] zero
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)    // [4:0] vertex_count
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Effective vertex count: zero counts as one, large values saturate
  function automatic int unsigned graph_size();
    if (count_reg == 0) return 1;
    if (count_reg > MAX_V) return MAX_V;
    return 32'(count_reg);
  endfunction

  // Two-colour the complement of rows 0..n-1, directed edges, first conflict ends it
  function automatic bit splits_in_two(input int unsigned n);
    logic [16:0]               wide;
    logic [tcsc_pkg::RowW-1:0] mask, seen, side, comp;
    int unsigned               visit [$];
    int unsigned               s, u, v;
    wide = (17'd1 << n) - 17'd1;
    mask = wide[tcsc_pkg::RowW-1:0];
    seen = '0;
    side = '0;
    for (s = 0; s < n; s++) begin
      if (seen[s]) continue;
      seen[s] = 1'b1;
      side[s] = 1'b1;
      visit = {visit, s};
      while (visit.size() != 0) begin
        u = visit.pop_front();
        comp = ~row_store[u] & mask;
        comp[u] = 1'b0;
        for (v = 0; v < n; v++) begin
          if (!comp[v]) continue;
          if (!seen[v]) begin
            seen[v] = 1'b1;
            side[v] = ~side[u];
            visit = {visit, v};
          end else if (side[v] == side[u]) begin
            return 1'b0;
          end
        end
      end
    end
    return 1'b1;
  endfunction

  // Store one accepted row; a completed graph queues its verdict
  function automatic void predict_row(input logic [tcsc_pkg::RowW-1:0] row);
    int unsigned n;
    bit          verdict;
    n = graph_size();
    if (rows_held < MAX_V) row_store[rows_held] = row;
    rows_held++;
    if (rows_held >= n) begin
      rows_held = 0;
      verdict = splits_in_two(n);
      split_expected = {split_expected, verdict};
    end
  endfunction

  function automatic int unsigned draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [tcsc_pkg::CountW-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return tcsc_pkg::CountW'($urandom_range(2, 8));
    if (roll == 7) return tcsc_pkg::CountW'($urandom_range(9, 16));
    if (roll == 8) return tcsc_pkg::CountW'($urandom_range(17, 31));
    return tcsc_pkg::CountW'($urandom_range(0, 1));
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Offer one row; valid stays high afterwards so back-to-back items need no gap
  task automatic send_row(input logic [tcsc_pkg::RowW-1:0] row);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= row;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_row(row);
    rows_sent++;
  endtask

  task automatic hold_rows();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_results_done();
    while (split_expected.size() != 0) @(posedge clk_i);
  endtask

  // Register write only with the block idle
  task automatic set_vertex_count(input logic [tcsc_pkg::CountW-1:0] value);
    hold_rows();
    wait_results_done();
    repeat (ROW_SETTLE) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    count_reg = value;
  endtask

  // Receive side: check each result, then stall for a drawn number of cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        if (split_expected.size() == 0) begin
          flag_mismatch($sformatf("result %h with no graph pending", m_tdata));
        end else begin
          want_split = split_expected.pop_front();
          if (m_tdata !== {{(tcsc_pkg::OutW-1){1'b0}}, want_split})
            flag_mismatch($sformatf("can_split: got %h, want %0d", m_tdata, want_split));
        end
        rx_wait = draw_gap();
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset count of 16, all-ones rows: complement is empty
  task automatic test_default_count();
    int unsigned i;
    for (i = 0; i < MAX_V; i++) send_row('1);
  endtask

  // Count of zero acts as one vertex; one vertex always splits
  task automatic test_tiny_counts();
    set_vertex_count(tcsc_pkg::CountW'(0));
    send_row('0);
    set_vertex_count(tcsc_pkg::CountW'(1));
    send_row('1);
  endtask

  // Two vertices, a triangle in the complement, and a one-way edge conflict
  task automatic test_small_graphs();
    set_vertex_count(tcsc_pkg::CountW'(2));
    send_row('0);
    send_row('0);
    set_vertex_count(tcsc_pkg::CountW'(3));
    send_row('0);
    send_row('0);
    send_row('0);
    send_row(tcsc_pkg::RowW'(16'h0006));
    send_row('0);
    send_row('0);
  endtask

  // Count lowered to the rows already held: the next row ends the graph
  task automatic test_count_change_mid_graph();
    set_vertex_count(tcsc_pkg::CountW'(4));
    send_row(tcsc_pkg::RowW'(16'h0003));
    send_row(tcsc_pkg::RowW'(16'h0003));
    set_vertex_count(tcsc_pkg::CountW'(2));
    send_row('0);
  endtask

  // Output held off while rows keep coming, then a full pause on the input
  task automatic test_output_hold_off();
    int unsigned i;
    set_vertex_count(tcsc_pkg::CountW'(1));
    no_idle = 1'b1;
    hold_requests++;
    for (i = 0; i < 12; i++) send_row(tcsc_pkg::RowW'($urandom()));
    hold_rows();
    wait_results_done();
    no_idle = 1'b0;
    for (i = 0; i < 12; i++) send_row(tcsc_pkg::RowW'($urandom()));
  endtask

  // Mostly two-clique graphs with random cross edges, some broken, some noise
  task automatic test_random_graphs();
    logic [tcsc_pkg::RowW-1:0] rows [MAX_V];
    logic [tcsc_pkg::RowW-1:0] side_mask;
    int unsigned               n, u, v, kind, cut, graphs;
    graphs = 0;
    while (rows_sent < TOTAL_ROWS) begin
      if ($urandom_range(0, 5) == 0) set_vertex_count(pick_count());
      no_idle = ($urandom_range(0, 7) == 0);
      n = graph_size();
      kind = $urandom_range(0, 9);
      side_mask = tcsc_pkg::RowW'($urandom());
      for (u = 0; u < MAX_V; u++) begin
        rows[u] = tcsc_pkg::RowW'($urandom());
        if (kind < 8) begin
          for (v = 0; v < n; v++)
            if (side_mask[v] == side_mask[u]) rows[u][v] = 1'b1;
        end
      end
      // broken split: drop one edge
      if (kind >= 6 && kind < 8) begin
        u = $urandom_range(0, n - 1);
        v = $urandom_range(0, n - 1);
        if (u != v) rows[u][v] = 1'b0;
      end
      cut = 0;
      if (n > 1 && $urandom_range(0, 19) == 0) cut = $urandom_range(1, n - 1);
      do begin
        send_row(rows[rows_held]);
        if (cut != 0 && rows_held == cut) begin
          cut = 0;
          set_vertex_count(pick_count());
        end
      end while (rows_held != 0);
      graphs++;
      if (graphs % 25 == 0) begin
        hold_rows();
        wait_results_done();
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_count();
    test_tiny_counts();
    test_small_graphs();
    test_count_change_mid_graph();
    test_output_hold_off();
    test_random_graphs();
    hold_rows();
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
